FILE: hw/rtl/lsgc_pkg.sv
package lsgc_pkg;

	// configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_START   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_STEP    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RANGE_LOW     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_RANGE_HIGH    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_PPM_Q8        = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_SENSOR_OFFSET = 3'd5;

	// cordic geometry, q4.14 vector, angle in units of 2*pi/65536
	localparam int CORDIC_STEPS = 14;
	localparam int VEC_W        = 18;
	localparam int ANG_W        = 17;
	localparam logic signed [VEC_W-1:0] CORDIC_GAIN = 18'sd9949;
	localparam logic signed [ANG_W-1:0] QUARTER     = 17'sd16384;
	localparam logic signed [ANG_W-1:0] HALF_TURN   = 17'sd32768;

	// scaling datapath widths
	localparam int XQ_W   = 32;            // range * trig + offset, mm * 2^14
	localparam int MAG_W  = XQ_W - 1;
	localparam int PPM_W  = 16;
	localparam int PROD_W = MAG_W + PPM_W;
	localparam int FRAC_SH = 22;
	localparam int U_W    = PROD_W + 1 - FRAC_SH;
	// divide by 1000 as multiply by ceil(2^36 / 1000), exact for u below 2^27
	localparam int RECIP_SH = 36;
	localparam int RECIP_W  = 27;
	localparam logic [RECIP_W-1:0] RECIP_K = 27'd68719477;
	localparam int QK_W   = U_W + RECIP_W;
	localparam int Q_W    = QK_W - RECIP_SH;
	localparam logic [PROD_W:0] ROUND_HALF = (PROD_W + 1)'(500) << FRAC_SH;

	// state handed from one rotation stage to the next
	typedef struct packed {
		logic                    ok;
		logic                    neg;
		logic [15:0]             range;
		logic signed [VEC_W-1:0] x;
		logic signed [VEC_W-1:0] y;
		logic signed [ANG_W-1:0] z;
	} cordic_t;

	// atan(2^-i) in units of 2*pi/65536, rounded to nearest
	function automatic logic signed [ANG_W-1:0] atan_turn(input int i);
		logic signed [ANG_W-1:0] a;
		case (i)
			0:       a = 17'sd8192;
			1:       a = 17'sd4836;
			2:       a = 17'sd2555;
			3:       a = 17'sd1297;
			4:       a = 17'sd651;
			5:       a = 17'sd326;
			6:       a = 17'sd163;
			7:       a = 17'sd81;
			8:       a = 17'sd41;
			9:       a = 17'sd20;
			10:      a = 17'sd10;
			11:      a = 17'sd5;
			12:      a = 17'sd3;
			13:      a = 17'sd1;
			default: a = 17'sd0;
		endcase
		return a;
	endfunction

endpackage

FILE: hw/rtl/lsgc_cordic_cell.sv
module lsgc_cordic_cell #(
	parameter int STEP = 0
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_vld,
	input  lsgc_pkg::cordic_t in_data,
	output logic              out_vld,
	output lsgc_pkg::cordic_t out_data
);
	import lsgc_pkg::*;

	logic signed [VEC_W-1:0] dx;
	logic signed [VEC_W-1:0] dy;
	logic signed [ANG_W-1:0] at;
	cordic_t                 nxt;
	cordic_t                 rot_s1;
	logic                    vld_s1;

	// one micro-rotation, direction from the sign of the residual angle
	always_comb begin
		dx  = in_data.y >>> STEP;
		dy  = in_data.x >>> STEP;
		at  = atan_turn(STEP);
		nxt = in_data;
		if (in_data.z >= 0) begin
			nxt.x = in_data.x - dx;
			nxt.y = in_data.y + dy;
			nxt.z = in_data.z - at;
		end else begin
			nxt.x = in_data.x + dx;
			nxt.y = in_data.y - dy;
			nxt.z = in_data.z + at;
		end
	end

	// stage register, payload without reset
	always_ff @(posedge clk) begin
		if (en) begin
			rot_s1 <= nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
		end
	end

	assign out_vld  = vld_s1;
	assign out_data = rot_s1;

endmodule

FILE: hw/rtl/lsgc_axis.sv
module lsgc_axis (
	input  logic                          clk,
	input  logic                          en,
	input  logic signed [lsgc_pkg::XQ_W-1:0] val,
	input  logic [lsgc_pkg::PPM_W-1:0]       ppm,
	output logic signed [lsgc_pkg::Q_W:0]    res
);
	import lsgc_pkg::*;

	logic              neg_s1, neg_s2, neg_s3, neg_s4;
	logic [MAG_W-1:0]  mag_s1;
	logic [PROD_W-1:0] prod_s2;
	logic [U_W-1:0]    u_s3;
	logic [QK_W-1:0]   qk_s4;
	logic signed [Q_W:0] res_s5;

	logic [XQ_W-1:0]   mag_v;
	logic [PROD_W:0]   biased_v;
	logic [Q_W:0]      q_v;

	always_comb begin
		mag_v    = val[XQ_W-1] ? XQ_W'(-val) : XQ_W'(val);
		biased_v = {1'b0, prod_s2} + ROUND_HALF;
		q_v      = {1'b0, qk_s4[QK_W-1:RECIP_SH]};
	end

	// magnitude, scale, add half and drop fraction, divide by 1000, restore sign
	always_ff @(posedge clk) begin
		if (en) begin
			neg_s1  <= val[XQ_W-1];
			mag_s1  <= mag_v[MAG_W-1:0];
			neg_s2  <= neg_s1;
			prod_s2 <= PROD_W'(mag_s1) * PROD_W'(ppm);
			neg_s3  <= neg_s2;
			u_s3    <= biased_v[PROD_W:FRAC_SH];
			neg_s4  <= neg_s3;
			qk_s4   <= QK_W'(u_s3) * QK_W'(RECIP_K);
			res_s5  <= neg_s4 ? -$signed(q_v) : $signed(q_v);
		end
	end

	assign res = res_s5;

endmodule

FILE: hw/rtl/laser_scan_to_grid_cell_unit.sv
// channel  direction  handshake              payload
// in       sink       in_valid / in_stall    beam_index, range_mm
// out      source     out_valid / out_stall  hit, row, col
// cfg      sink       cfg_we                 cfg_index, cfg_data
//
// one beam per cycle sustained while the output is not stalled; the path from input
// transfer to result runs through intake, angle fold, 14 rotation stages, sign fix,
// range product, 5 scaling stages and the output register
// reset clears all valid flags and loads the register reset values
// a held result freezes the whole pipeline; input is stalled only while the
// output register holds an untaken result
module laser_scan_to_grid_cell_unit #(
	parameter int GRID_SIZE = 256,
	parameter int MAX_BEAMS = 1024
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [9:0]                         beam_index,
	input  logic [15:0]                        range_mm,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic                               hit,
	output logic [7:0]                         row,
	output logic [7:0]                         col,
	input  logic                               cfg_we,
	input  logic [lsgc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [15:0]                        cfg_data
);
	import lsgc_pkg::*;

	localparam int AX_LAT = 5;
	localparam int POS_W  = Q_W + 3;
	localparam logic signed [POS_W-1:0] GRID_HALF = POS_W'(GRID_SIZE / 2);
	localparam logic signed [POS_W-1:0] GRID_END  = POS_W'(GRID_SIZE);

	// configuration registers
	logic [15:0] angle_start_q, angle_step_q, range_low_q, range_high_q;
	logic [15:0] ppm_q, offset_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angle_start_q <= 16'd0;
			angle_step_q  <= 16'd64;
			range_low_q   <= 16'd0;
			range_high_q  <= 16'd65535;
			ppm_q         <= 16'd5120;
			offset_q      <= 16'd0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ANGLE_START:   angle_start_q <= cfg_data;
				CFG_ANGLE_STEP:    angle_step_q  <= cfg_data;
				CFG_RANGE_LOW:     range_low_q   <= cfg_data;
				CFG_RANGE_HIGH:    range_high_q  <= cfg_data;
				CFG_PPM_Q8:        ppm_q         <= cfg_data;
				CFG_SENSOR_OFFSET: offset_q      <= cfg_data;
				default: ;
			endcase
		end
	end

	// global advance: everything moves unless a result is held
	logic en;
	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;

	// intake: beam angle and range gate
	logic [25:0] idx_prod;
	logic        ok_v;
	logic        vld_s1, ok_s1;
	logic [15:0] angle_s1, range_s1;

	always_comb begin
		idx_prod = 26'(beam_index) * 26'(angle_step_q);
		ok_v     = (int'(beam_index) < MAX_BEAMS) && (range_mm > range_low_q)
			&& (range_mm < range_high_q);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ok_s1    <= ok_v;
			angle_s1 <= angle_start_q + idx_prod[15:0];
			range_s1 <= range_mm;
		end
	end

	// fold the angle into the right half plane
	logic signed [ANG_W-1:0] z_v;
	cordic_t                 fold_v;
	cordic_t                 fold_s2;
	logic                    vld_s2;

	always_comb begin
		z_v          = $signed({angle_s1[15], angle_s1});
		fold_v.ok    = ok_s1;
		fold_v.range = range_s1;
		fold_v.x     = CORDIC_GAIN;
		fold_v.y     = '0;
		fold_v.neg   = 1'b0;
		fold_v.z     = z_v;
		if (z_v > QUARTER) begin
			fold_v.z   = z_v - HALF_TURN;
			fold_v.neg = 1'b1;
		end else if (z_v < -QUARTER) begin
			fold_v.z   = z_v + HALF_TURN;
			fold_v.neg = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fold_s2 <= fold_v;
		end
	end

	// chain of rotation stages
	cordic_t                 chain [0:CORDIC_STEPS];
	logic [CORDIC_STEPS:0]   cvld;

	assign chain[0] = fold_s2;
	assign cvld[0]  = vld_s2;

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
		lsgc_cordic_cell #(
			.STEP(i)
		) u_rot (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.in_vld   (cvld[i]),
			.in_data  (chain[i]),
			.out_vld  (cvld[i+1]),
			.out_data (chain[i+1])
		);
	end

	// undo the fold on cos and sin
	cordic_t                 last_c;
	logic                    vld_s3, ok_s3;
	logic [15:0]             range_s3;
	logic signed [VEC_W-1:0] c_s3, s_s3;

	assign last_c = chain[CORDIC_STEPS];

	always_ff @(posedge clk) begin
		if (en) begin
			ok_s3    <= last_c.ok;
			range_s3 <= last_c.range;
			c_s3     <= last_c.neg ? -last_c.x : last_c.x;
			s_s3     <= last_c.neg ? -last_c.y : last_c.y;
		end
	end

	// end point in mm * 2^14
	logic signed [VEC_W+16:0] rc_v, rs_v;
	logic [XQ_W-1:0]          off_v;
	logic                     vld_s4, ok_s4;
	logic signed [XQ_W-1:0]   xq_s4, yq_s4;

	always_comb begin
		rc_v  = $signed({1'b0, range_s3}) * c_s3;
		rs_v  = $signed({1'b0, range_s3}) * s_s3;
		off_v = {{(XQ_W - 30){offset_q[15]}}, offset_q, 14'd0};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ok_s4 <= ok_s3;
			xq_s4 <= $signed(rc_v[XQ_W-1:0] + off_v);
			yq_s4 <= $signed(rs_v[XQ_W-1:0]);
		end
	end

	// pixel offsets, one scaler per axis
	logic signed [Q_W:0] rx, ry;

	lsgc_axis u_axis_x (
		.clk (clk),
		.en  (en),
		.val (xq_s4),
		.ppm (ppm_q),
		.res (rx)
	);

	lsgc_axis u_axis_y (
		.clk (clk),
		.en  (en),
		.val (yq_s4),
		.ppm (ppm_q),
		.res (ry)
	);

	// valid and range flags alongside the scalers
	logic [AX_LAT-1:0] vld_ax_q, ok_ax_q;

	always_ff @(posedge clk) begin
		if (en) begin
			ok_ax_q <= {ok_ax_q[AX_LAT-2:0], ok_s4};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1   <= 1'b0;
			vld_s2   <= 1'b0;
			vld_s3   <= 1'b0;
			vld_s4   <= 1'b0;
			vld_ax_q <= '0;
		end else if (en) begin
			vld_s1   <= in_valid;
			vld_s2   <= vld_s1;
			vld_s3   <= cvld[CORDIC_STEPS];
			vld_s4   <= vld_s3;
			vld_ax_q <= {vld_ax_q[AX_LAT-2:0], vld_s4};
		end
	end

	// grid cell and bounds check after rounding
	logic signed [POS_W-1:0] row_v, col_v;
	logic                    hit_v;
	logic                    out_valid_q, hit_q;
	logic [7:0]              row_q, col_q;

	always_comb begin
		row_v = GRID_HALF + POS_W'(ry);
		col_v = GRID_HALF - POS_W'(rx);
		hit_v = ok_ax_q[AX_LAT-1] && (row_v >= 0) && (row_v < GRID_END)
			&& (col_v >= 0) && (col_v < GRID_END);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hit_q <= hit_v;
			row_q <= hit_v ? row_v[7:0] : 8'd0;
			col_q <= hit_v ? col_v[7:0] : 8'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= vld_ax_q[AX_LAT-1];
		end
	end

	assign out_valid = out_valid_q;
	assign hit       = hit_q;
	assign row       = row_q;
	assign col       = col_q;

	// residual angle has converged after the last rotation
	assert property (@(posedge clk) disable iff (!arst_n)
		cvld[CORDIC_STEPS] |-> (last_c.z <= 4) && (last_c.z >= -4))
		else $error("cordic residual angle did not converge");

	// a result without a hit carries a zero cell
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !hit) |-> (row == 8'd0) && (col == 8'd0))
		else $error("miss result with nonzero cell");

	// a held result freezes the rotation chain
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> $stable(cvld))
		else $error("rotation chain moved while output held");

endmodule

FILE: tb/laser_scan_to_grid_cell_unit_tb.sv
`timescale 1ns / 1ps

module laser_scan_to_grid_cell_unit_tb;
	import lsgc_pkg::*;

	localparam int GRID_DIM     = 256;
	localparam int BEAM_LIMIT   = 1024;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = 40;
	localparam int REPORT_MAX   = 10;
	localparam longint SCALE_DEN = 64'd1000 * (64'd1 << 22);

	// unused register slots, writes there must change nothing
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;

	typedef struct packed {
		logic       hit;
		logic [7:0] row;
		logic [7:0] col;
	} pixel_t;

	// grid projection predictor and queue of pending grid pixels
	class grid_pixel_board;
		logic signed [15:0] angle_start;
		logic signed [15:0] angle_step;
		logic signed [15:0] sensor_offset;
		logic [15:0]        range_low;
		logic [15:0]        range_high;
		logic [15:0]        ppm;
		int                 arc_step [14];
		pixel_t             expected_pixels [$];
		int                 mismatches;

		function new();
			arc_step = '{8192, 4836, 2555, 1297, 651, 326, 163, 81, 41, 20, 10, 5, 3, 1};
			angle_start   = 16'sd0;
			angle_step    = 16'sd64;
			range_low     = 16'd0;
			range_high    = 16'd65535;
			ppm           = 16'd5120;
			sensor_offset = 16'sd0;
			mismatches    = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] v);
			case (idx)
				CFG_ANGLE_START:   angle_start = v;
				CFG_ANGLE_STEP:    angle_step = v;
				CFG_RANGE_LOW:     range_low = v;
				CFG_RANGE_HIGH:    range_high = v;
				CFG_PPM_Q8:        ppm = v;
				CFG_SENSOR_OFFSET: sensor_offset = v;
				default: ;
			endcase
		endfunction

		// round(v * ppm / (1000 * 2^22)), ties away from zero
		function longint scale_px(longint v);
			longint p, m, q;
			p = v * longint'(ppm);
			m = (p < 0) ? -p : p;
			q = (m + SCALE_DEN / 2) / SCALE_DEN;
			return (p < 0) ? -q : q;
		endfunction

		function pixel_t project_beam(logic [9:0] idx, logic [15:0] rng);
			pixel_t     px;
			logic [15:0] angle;
			int         z, cx, sy, dx, dy;
			bit         flip;
			longint     xq, yq, r_row, r_col;
			px = '0;
			if (int'(idx) >= BEAM_LIMIT || !(rng > range_low && rng < range_high)) begin
				return px;
			end
			angle = 16'(int'(angle_start) + int'(idx) * int'(angle_step));
			// fold into the right half plane, negate the vector afterwards
			z = int'($signed(angle));
			flip = 1'b0;
			if (z > 16384) begin
				z -= 32768;
				flip = 1'b1;
			end else if (z < -16384) begin
				z += 32768;
				flip = 1'b1;
			end
			// rotation steps, shifts floor toward minus infinity
			cx = 9949;
			sy = 0;
			for (int i = 0; i < 14; i++) begin
				dx = sy >>> i;
				dy = cx >>> i;
				if (z >= 0) begin
					cx -= dx;
					sy += dy;
					z -= arc_step[i];
				end else begin
					cx += dx;
					sy -= dy;
					z += arc_step[i];
				end
			end
			if (flip) begin
				cx = -cx;
				sy = -sy;
			end
			// end point in mm * 2^14, then scaled to grid pixels
			xq = longint'(rng) * cx + longint'(sensor_offset) * 16384;
			yq = longint'(rng) * sy;
			r_row = GRID_DIM / 2 + scale_px(yq);
			r_col = GRID_DIM / 2 - scale_px(xq);
			if (r_row >= 0 && r_row < GRID_DIM && r_col >= 0 && r_col < GRID_DIM) begin
				px.hit = 1'b1;
				px.row = 8'(r_row);
				px.col = 8'(r_col);
			end
			return px;
		endfunction

		function void note_beam(logic [9:0] idx, logic [15:0] rng);
			expected_pixels.insert(expected_pixels.size(), project_beam(idx, rng));
		endfunction

		function void check_pixel(pixel_t got);
			pixel_t want;
			if (expected_pixels.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_MAX) begin
					$display("unexpected grid result: hit=%0d row=%0d col=%0d",
						got.hit, got.row, got.col);
				end
				return;
			end
			want = expected_pixels.pop_front();
			if (got.hit !== want.hit || got.row !== want.row || got.col !== want.col) begin
				mismatches++;
				if (mismatches <= REPORT_MAX) begin
					$display({"grid pixel mismatch: expected hit=%0d row=%0d col=%0d,",
						" got hit=%0d row=%0d col=%0d"},
						want.hit, want.row, want.col, got.hit, got.row, got.col);
				end
			end
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_stall;
	logic [9:0]           beam_index;
	logic [15:0]          range_mm;
	logic                 out_valid;
	logic                 out_stall;
	logic                 hit;
	logic [7:0]           row;
	logic [7:0]           col;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [15:0]          cfg_data;

	bit              calm = 1'b0;
	int              gap_odds = 20;
	int              stall_odds = 20;
	int              cycle_count = 0;
	grid_pixel_board board;

	laser_scan_to_grid_cell_unit #(
		.GRID_SIZE(GRID_DIM),
		.MAX_BEAMS(BEAM_LIMIT)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.beam_index(beam_index),
		.range_mm(range_mm),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.hit(hit),
		.row(row),
		.col(col),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("laser_scan_to_grid_cell_unit_tb failed");
			$finish;
		end
	end

	// result side back-pressure in bursts
	initial begin
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (!calm && $urandom_range(0, 99) < stall_odds) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 9)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// check every result transfer
	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
			board.check_pixel({hit, row, col});
		end
	end

	task automatic send_beam(input logic [9:0] idx, input logic [15:0] rng);
		if (!calm && $urandom_range(0, 99) < gap_odds) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		in_valid   <= 1'b1;
		beam_index <= idx;
		range_mm   <= rng;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		board.note_beam(idx, rng);
	endtask

	task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] v);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= v;
		@(posedge clk);
		board.write_reg(idx, v);
	endtask

	// reprogram only once every beam in flight has come out
	task automatic set_grid(input logic [15:0] start, input logic [15:0] step,
		input logic [15:0] low, input logic [15:0] high, input logic [15:0] scale,
		input logic [15:0] offset);
		in_valid <= 1'b0;
		while (board.expected_pixels.size() != 0) @(posedge clk);
		put_reg(CFG_ANGLE_START, start);
		put_reg(CFG_ANGLE_STEP, step);
		put_reg(CFG_RANGE_LOW, low);
		put_reg(CFG_RANGE_HIGH, high);
		put_reg(CFG_PPM_Q8, scale);
		put_reg(CFG_SENSOR_OFFSET, offset);
		put_reg(CFG_SPARE_A, 16'($urandom));
		put_reg(CFG_SPARE_B, 16'($urandom));
		cfg_we <= 1'b0;
	endtask

	task automatic random_grid();
		logic [15:0] step, low, high, scale, offset;
		step = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 512) - 256);
		low = $urandom_range(0, 1) ? 16'($urandom_range(0, 3000)) : 16'h0000;
		high = ($urandom_range(0, 3) == 0) ? 16'($urandom)
			: 16'(65535 - $urandom_range(0, 20000));
		scale = $urandom_range(0, 1) ? 16'($urandom_range(1, 65535))
			: 16'($urandom_range(1500, 12000));
		offset = ($urandom_range(0, 3) == 0) ? 16'($urandom)
			: 16'($urandom_range(0, 1000) - 500);
		set_grid(16'($urandom), step, low, high, scale, offset);
	endtask

	// mostly ranges that land near the grid at the current scale
	function automatic logic [15:0] pick_range();
		int reach;
		reach = (board.ppm == 0) ? 65535 : 32768000 / int'(board.ppm) + 300;
		if (reach > 65535) begin
			reach = 65535;
		end
		if ($urandom_range(0, 3) != 0) begin
			return 16'($urandom_range(0, reach));
		end
		return 16'($urandom);
	endfunction

	function automatic void shuffle_idling();
		case ($urandom_range(0, 2))
			0: gap_odds = 0;
			1: gap_odds = 10;
			default: gap_odds = 35;
		endcase
		case ($urandom_range(0, 2))
			0: stall_odds = 0;
			1: stall_odds = 8;
			default: stall_odds = 30;
		endcase
	endfunction

	task automatic run_random(input int count);
		repeat (count) send_beam(10'($urandom_range(0, 1023)), pick_range());
	endtask

	initial begin
		board = new();
		arst_n     <= 1'b0;
		in_valid   <= 1'b0;
		beam_index <= '0;
		range_mm   <= '0;
		cfg_we     <= 1'b0;
		cfg_index  <= CFG_ANGLE_START;
		cfg_data   <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: range limits, grid borders, quadrant and fold points
		send_beam(10'd0, 16'd0);
		send_beam(10'd0, 16'd65535);
		send_beam(10'd0, 16'd1);
		send_beam(10'd0, 16'd65534);
		send_beam(10'd0, 16'd6400);
		send_beam(10'd0, 16'd6425);
		send_beam(10'd256, 16'd6350);
		send_beam(10'd256, 16'd6400);
		send_beam(10'd512, 16'd3000);
		send_beam(10'd768, 16'd3000);
		send_beam(10'd300, 16'd2000);
		send_beam(10'd1023, 16'd5000);
		send_beam(10'd682, 16'd4000);
		send_beam(10'd100, 16'hAAAA);
		send_beam(10'd923, 16'h5555);

		// extreme settings, fine scale and most negative offset
		set_grid(16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'hFFFF, 16'h8000);
		send_beam(10'd0, 16'd1);
		send_beam(10'd1023, 16'd65534);
		send_beam(10'd1, 16'd300);
		send_beam(10'd512, 16'd400);
		send_beam(10'd700, 16'd250);
		run_random(50);

		// coarsest nonzero scale, largest offset
		shuffle_idling();
		set_grid(16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 16'h0001, 16'h7FFF);
		run_random(40);

		// zero scale collapses onto the centre pixel
		shuffle_idling();
		set_grid(16'($urandom), 16'($urandom), 16'd0, 16'hFFFF, 16'h0000, 16'($urandom));
		run_random(40);

		// empty and inverted range windows
		set_grid(16'($urandom), 16'd64, 16'd5000, 16'd5000, 16'd5120, 16'd0);
		run_random(20);
		set_grid(16'($urandom), 16'd64, 16'hFFFF, 16'h0000, 16'd5120, 16'd0);
		run_random(20);

		repeat (6) begin
			shuffle_idling();
			random_grid();
			run_random(60);
		end

		// closing stretch at full rate
		calm = 1'b1;
		random_grid();
		run_random(80);
		in_valid <= 1'b0;

		while (board.expected_pixels.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (board.mismatches == 0 && board.expected_pixels.size() == 0) begin
			$display("laser_scan_to_grid_cell_unit_tb passed");
		end else begin
			$display("laser_scan_to_grid_cell_unit_tb failed");
		end
		$finish;
	end

endmodule
